/* src/fcv_pkg.sv */
// ---------------------------------------------------------------------------
// fcv_pkg
// Shared types, register codes and helpers for the flash CRC verifier.
// ---------------------------------------------------------------------------
package fcv_pkg;

    typedef enum logic [1:0] {
        WIDTH_8       = 2'd0,
        WIDTH_16      = 2'd1,
        WIDTH_32      = 2'd2,
        WIDTH_INVALID = 2'd3
    } width_code_t;

    typedef enum logic [1:0] {
        REG_WIDTH_CODE  = 2'd0,
        REG_POLYNOMIAL  = 2'd1,
        REG_CRC_IN_DATA = 2'd2,
        REG_LAST_INDEX  = 2'd3
    } cfg_reg_t;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam width_code_t       RST_WIDTH_CODE  = WIDTH_32;
    localparam logic [CRC_W-1:0]  RST_POLYNOMIAL  = 32'h04C1_1DB7;
    localparam logic              RST_CRC_IN_DATA = 1'b1;
    localparam logic [CRC_W-1:0]  RST_LAST_INDEX  = 32'h0000_0000;

    typedef struct packed {
        width_code_t      width_code;
        logic [CRC_W-1:0] polynomial;
    } crc_cfg_t;

    function automatic logic [CRC_W-1:0] width_mask(input width_code_t code);
        logic [CRC_W-1:0] m;
        case (code)
            WIDTH_8:  m = 32'h0000_00FF;
            WIDTH_16: m = 32'h0000_FFFF;
            WIDTH_32: m = 32'hFFFF_FFFF;
            default:  m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    // bytes occupied by the stored CRC
    function automatic logic [2:0] crc_bytes(input width_code_t code);
        logic [2:0] n;
        case (code)
            WIDTH_8:  n = 3'd1;
            WIDTH_16: n = 3'd2;
            WIDTH_32: n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

/* src/flash_crc_verifier_core.sv */
// ---------------------------------------------------------------------------
// flash_crc_verifier_core
// Byte-stream CRC check of a memory range, one result per run.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_data_byte
// m_        out        m_valid/m_ready    m_crc_value, m_check_failed, m_ever_nonzero
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One byte per cycle unless the final byte waits; CRC feedback is combinational.
// The final byte is held in in_byte_reg before its result is registered.
// Reset loads register defaults and clears CRC, position and nonzero flag.
// Only the final byte of a run waits when the result register is still full.
// ---------------------------------------------------------------------------
module flash_crc_verifier_core
    import fcv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CRC_W-1:0]      m_crc_value,
    output logic                  m_check_failed,
    output logic                  m_ever_nonzero,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    width_code_t       width_code_reg;
    logic [CRC_W-1:0]  polynomial_reg;
    logic              crc_in_data_reg;
    logic [CRC_W-1:0]  last_index_reg;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [CRC_W-1:0]  pos_reg, pos_next;
    logic              seen_reg, seen_next;

    logic              out_valid_reg, out_valid_next;
    logic [CRC_W-1:0]  out_crc_reg;
    logic              out_failed_reg;
    logic              out_seen_reg;

    crc_cfg_t          cfg;
    logic              is_last;
    logic              fire;
    logic              replace;
    logic [CRC_W:0]    pos_plus;
    logic [BYTE_W-1:0] data_eff;
    logic [CRC_W-1:0]  crc_new;
    logic              seen_upd;
    logic              failed;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_code_reg  <= RST_WIDTH_CODE;
            polynomial_reg  <= RST_POLYNOMIAL;
            crc_in_data_reg <= RST_CRC_IN_DATA;
            last_index_reg  <= RST_LAST_INDEX;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH_CODE:  width_code_reg  <= width_code_t'(cfg_wdata[1:0]);
                REG_POLYNOMIAL:  polynomial_reg  <= cfg_wdata[CRC_W-1:0];
                REG_CRC_IN_DATA: crc_in_data_reg <= cfg_wdata[0];
                REG_LAST_INDEX:  last_index_reg  <= cfg_wdata[CRC_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.width_code = width_code_reg;
    assign cfg.polynomial = polynomial_reg;

    assign is_last  = (pos_reg == last_index_reg);
    assign fire     = in_valid_reg && (!is_last || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || fire;

    // external CRC bytes read as zero
    assign pos_plus = {1'b0, pos_reg} + {30'h0, crc_bytes(width_code_reg)};
    assign replace  = !crc_in_data_reg && (width_code_reg != WIDTH_INVALID)
                      && (pos_plus > {1'b0, last_index_reg});
    assign data_eff = replace ? '0 : in_byte_reg;

    fcv_byte_update u_byte_update (
        .cfg     (cfg),
        .crc_in  (crc_reg),
        .data_in (data_eff),
        .crc_out (crc_new)
    );

    assign seen_upd = seen_reg || (crc_new != '0);
    assign failed   = crc_in_data_reg &&
                      ((width_code_reg == WIDTH_INVALID) || (crc_new != '0) || !seen_upd);

    always_comb begin
        in_valid_next  = in_valid_reg;
        crc_next       = crc_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        if (fire) begin
            if (is_last) begin
                crc_next       = '0;
                pos_next       = '0;
                seen_next      = 1'b0;
                out_valid_next = 1'b1;
            end else begin
                crc_next  = crc_new;
                pos_next  = pos_reg + 32'd1;
                seen_next = seen_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            crc_reg       <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
        if (fire && is_last) begin
            out_crc_reg    <= crc_new;
            out_failed_reg <= failed;
            out_seen_reg   <= seen_upd;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_crc_value    = out_crc_reg;
    assign m_check_failed = out_failed_reg;
    assign m_ever_nonzero = out_seen_reg;

    // external mode never fails
    a_ext_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !crc_in_data_reg) |-> !out_failed_reg)
        else $error("external mode result flagged as failed");

    // invalid width gives an empty result
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && width_code_reg == WIDTH_INVALID)
            |-> (out_crc_reg == '0 && !out_seen_reg))
        else $error("invalid width produced nonzero CRC or flag");

    // run state clears after the final byte
    a_run_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_last) |=> (pos_reg == '0 && crc_reg == '0 && !seen_reg))
        else $error("run state not cleared after final byte");

    // updated CRC stays within the selected width
    a_crc_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        (crc_new & ~width_mask(width_code_reg)) == '0)
        else $error("CRC update exceeds selected width");

    // a held byte blocks the next request
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |-> !s_ready)
        else $error("request accepted while held byte pending");

endmodule

/* src/fcv_byte_update.sv */
// ---------------------------------------------------------------------------
// fcv_byte_update
// One byte step of the augmented MSB-first CRC (8, 16 or 32 bit).
// ---------------------------------------------------------------------------
module fcv_byte_update
    import fcv_pkg::*;
(
    input  crc_cfg_t          cfg,
    input  logic [CRC_W-1:0]  crc_in,
    input  logic [BYTE_W-1:0] data_in,
    output logic [CRC_W-1:0]  crc_out
);

    always_comb begin
        logic [CRC_W-1:0]  crc_m;
        logic [BYTE_W-1:0] top;
        logic [CRC_W-1:0]  shifted;
        logic [CRC_W-1:0]  poly_lj;
        logic [CRC_W-1:0]  v;
        logic [CRC_W-1:0]  tbl;

        crc_m = crc_in & width_mask(cfg.width_code);
        case (cfg.width_code)
            WIDTH_8: begin
                top     = crc_m[7:0];
                shifted = {24'h0, data_in};
                poly_lj = {cfg.polynomial[7:0], 24'h0};
            end
            WIDTH_16: begin
                top     = crc_m[15:8];
                shifted = {16'h0, crc_m[7:0], data_in};
                poly_lj = {cfg.polynomial[15:0], 16'h0};
            end
            WIDTH_32: begin
                top     = crc_m[31:24];
                shifted = {crc_m[23:0], data_in};
                poly_lj = cfg.polynomial;
            end
            default: begin
                top     = '0;
                shifted = '0;
                poly_lj = '0;
            end
        endcase

        // left-justified so one datapath serves every width
        v = {top, 24'h0};
        for (int k = 0; k < BYTE_W; k++) begin
            v = v[CRC_W-1] ? ({v[CRC_W-2:0], 1'b0} ^ poly_lj) : {v[CRC_W-2:0], 1'b0};
        end

        case (cfg.width_code)
            WIDTH_8:  tbl = {24'h0, v[31:24]};
            WIDTH_16: tbl = {16'h0, v[31:16]};
            WIDTH_32: tbl = v;
            default:  tbl = '0;
        endcase

        crc_out = (cfg.width_code == WIDTH_INVALID) ? '0 : (shifted ^ tbl);
    end

endmodule

/* dv/tb_flash_crc_verifier_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_flash_crc_verifier_core
// Self-checking bench for the flash CRC verifier core. A queue-fed driver
// streams byte requests, a shadow of the augmented CRC computes each run's
// verdict on acceptance, and a monitor compares results in order. Runs are
// mostly well-formed embedded-CRC images, with corrupted, random, external
// and invalid-width runs mixed in, under random source and sink idling.
// ---------------------------------------------------------------------------
module tb_flash_crc_verifier_core;
    import fcv_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300_000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned RANDOM_BYTES = 400;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             check_failed;
        logic             ever_nonzero;
    } crc_verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CRC_W-1:0]      m_crc_value;
    logic                  m_check_failed;
    logic                  m_ever_nonzero;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // shadow registers and running state
    width_code_t      shadow_width = RST_WIDTH_CODE;
    logic [CRC_W-1:0] shadow_poly = RST_POLYNOMIAL;
    logic             shadow_embedded = RST_CRC_IN_DATA;
    logic [CRC_W-1:0] shadow_last = RST_LAST_INDEX;
    logic [CRC_W-1:0] run_crc = '0;
    logic [CRC_W-1:0] run_pos = '0;
    logic             run_seen = 1'b0;

    logic [BYTE_W-1:0] flash_bytes[$];
    crc_verdict_t      pending_verdicts[$];
    crc_verdict_t      want;

    int unsigned src_idle_max = 13;
    int unsigned sink_idle_max = 13;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned random_bytes_sent = 0;

    flash_crc_verifier_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_crc_value    (m_crc_value),
        .m_check_failed (m_check_failed),
        .m_ever_nonzero (m_ever_nonzero),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned crc_width_bits(input width_code_t code);
        case (code)
            WIDTH_8:  return 8;
            WIDTH_16: return 16;
            WIDTH_32: return 32;
            default:  return 0;
        endcase
    endfunction

    function automatic logic [CRC_W-1:0] width_ones(input int unsigned w);
        return (w == 32) ? '1 : ((32'd1 << w) - 32'd1);
    endfunction

    // one table-driven step: shift the byte in low, fold the top byte back
    function automatic logic [CRC_W-1:0] crc_byte_step(input logic [CRC_W-1:0] crc_in,
                                                       input logic [7:0] d,
                                                       input int unsigned w,
                                                       input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] msk;
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] fb;
        logic [CRC_W-1:0] top_bit;
        int unsigned      k;
        msk = width_ones(w);
        crc = crc_in & msk;
        fb = (crc >> (w - 8)) & 32'hFF;
        top_bit = 32'd1 << (w - 1);
        for (k = 0; k < w; k++) begin
            if ((fb & top_bit) != 0) begin
                fb = ((fb << 1) ^ poly) & msk;
            end else begin
                fb = (fb << 1) & msk;
            end
        end
        if (w == 8) begin
            crc = {24'h0, d};
        end else begin
            crc = ((crc << 8) | {24'h0, d}) & msk;
        end
        return crc ^ fb;
    endfunction

    function automatic void absorb_flash_byte(input logic [7:0] b);
        int unsigned      w;
        logic [7:0]       d;
        logic [CRC_W-1:0] crc;
        crc_verdict_t     v;
        w = crc_width_bits(shadow_width);
        d = b;
        crc = run_crc & width_ones(w);
        if (w != 0) begin
            // external mode: trailing CRC bytes read as zero
            if (!shadow_embedded && ({1'b0, run_pos} + 33'(w / 8) > {1'b0, shadow_last})) begin
                d = 8'h00;
            end
            crc = crc_byte_step(crc, d, w, shadow_poly);
            if (crc != 0) begin
                run_seen = 1'b1;
            end
        end else begin
            crc = '0;
        end
        run_crc = crc;
        if (run_pos != shadow_last) begin
            run_pos = run_pos + 32'd1;
            return;
        end
        v.crc_value    = crc & width_ones(w);
        v.check_failed = shadow_embedded && (w == 0 || crc != 0 || !run_seen);
        v.ever_nonzero = run_seen;
        pending_verdicts.push_back(v);
        run_crc  = '0;
        run_pos  = '0;
        run_seen = 1'b0;
    endfunction

    function automatic logic [7:0] random_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end
        if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom());
    endfunction

    // source: one request per pop, random gap drawn for each request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                absorb_flash_byte(s_data_byte);
            end
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (flash_bytes.size() != 0) begin
                s_valid <= 1'b1;
                s_data_byte <= flash_bytes.pop_front();
                src_gap = $urandom_range(0, src_idle_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink: stall drawn per result, counted down while a result waits
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, actual crc %h failed %b nonzero %b",
                             $time, m_crc_value, m_check_failed, m_ever_nonzero);
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_crc_value !== want.crc_value) begin
                        $display("%0t: crc_value mismatch, expected %h, actual %h",
                                 $time, want.crc_value, m_crc_value);
                        fail_count++;
                    end
                    if (m_check_failed !== want.check_failed) begin
                        $display("%0t: check_failed mismatch, expected %b, actual %b",
                                 $time, want.check_failed, m_check_failed);
                        fail_count++;
                    end
                    if (m_ever_nonzero !== want.ever_nonzero) begin
                        $display("%0t: ever_nonzero mismatch, expected %b, actual %b",
                                 $time, want.ever_nonzero, m_ever_nonzero);
                        fail_count++;
                    end
                end
                sink_gap = $urandom_range(0, sink_idle_max);
            end
            if (sink_gap > 0) begin
                m_ready <= 1'b0;
                if (m_valid) begin
                    sink_gap--;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("flash_crc_verifier_core verification failed");
            $finish;
        end
    end

    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (flash_bytes.size() != 0 || s_valid || pending_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH_CODE:  shadow_width = width_code_t'(val[1:0]);
            REG_POLYNOMIAL:  shadow_poly = val;
            REG_CRC_IN_DATA: shadow_embedded = val[0];
            REG_LAST_INDEX:  shadow_last = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input width_code_t wc, input logic [CRC_W-1:0] poly,
                              input logic embedded, input logic [CRC_W-1:0] last);
        wait_for_drain();
        program_reg(REG_WIDTH_CODE, 32'(wc));
        program_reg(REG_POLYNOMIAL, poly);
        program_reg(REG_CRC_IN_DATA, 32'(embedded));
        program_reg(REG_LAST_INDEX, last);
    endtask

    // well-formed: data followed by its augmented CRC, optionally with one bit flipped
    task automatic queue_run(input int unsigned len, input bit well_formed, input bit corrupt);
        int unsigned      w;
        int unsigned      nb;
        int unsigned      k;
        logic [CRC_W-1:0] crc;
        logic [7:0]       run_bytes[$];
        w  = crc_width_bits(shadow_width);
        nb = w / 8;
        if (well_formed && shadow_embedded && w != 0 && len >= nb) begin
            for (k = 0; k < len - nb; k++) begin
                run_bytes.push_back(random_byte());
            end
            crc = '0;
            foreach (run_bytes[i]) begin
                crc = crc_byte_step(crc, run_bytes[i], w, shadow_poly);
            end
            repeat (nb) crc = crc_byte_step(crc, 8'h00, w, shadow_poly);
            for (k = 0; k < nb; k++) begin
                run_bytes.push_back(8'(crc >> (w - 8 - 8 * k)));
            end
            if (corrupt) begin
                k = $urandom_range(0, len - 1);
                run_bytes[k] = run_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
            end
        end else begin
            for (k = 0; k < len; k++) begin
                run_bytes.push_back(random_byte());
            end
        end
        foreach (run_bytes[i]) begin
            flash_bytes.push_back(run_bytes[i]);
        end
        random_bytes_sent += len;
    endtask

    initial begin
        width_code_t      wc;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] last;
        logic             emb;
        int unsigned      r;
        int unsigned      runs;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: 32-bit, embedded, single-byte runs
        flash_bytes.push_back(8'hFF);
        flash_bytes.push_back(8'h00);

        set_config(WIDTH_8, 32'h0000_0007, 1'b1, 32'd2);
        queue_run(3, 1'b1, 1'b0);

        // external CRC, last two bytes zeroed
        set_config(WIDTH_16, 32'h0000_1021, 1'b0, 32'd3);
        flash_bytes.push_back(8'hFF);
        flash_bytes.push_back(8'h80);
        flash_bytes.push_back(8'h7F);
        flash_bytes.push_back(8'h01);

        // run shorter than the CRC itself: every byte zeroed
        set_config(WIDTH_32, 32'hFFFF_FFFF, 1'b0, 32'd1);
        flash_bytes.push_back(8'hFF);
        flash_bytes.push_back(8'hFF);

        set_config(WIDTH_32, 32'h0000_0000, 1'b1, 32'd4);
        queue_run(5, 1'b1, 1'b0);

        // invalid width in both modes
        set_config(WIDTH_INVALID, 32'h04C1_1DB7, 1'b1, 32'd0);
        flash_bytes.push_back(8'hC3);
        set_config(WIDTH_INVALID, 32'h04C1_1DB7, 1'b0, 32'd0);
        flash_bytes.push_back(8'h3C);

        // all-zero image never goes nonzero
        set_config(WIDTH_16, 32'h0000_8005, 1'b1, 32'd1);
        flash_bytes.push_back(8'h00);
        flash_bytes.push_back(8'h00);

        // registers changed part way through a run
        set_config(WIDTH_32, 32'h04C1_1DB7, 1'b0, 32'hFFFF_FFFF);
        flash_bytes.push_back(8'h12);
        flash_bytes.push_back(8'h34);
        flash_bytes.push_back(8'h56);
        wait_for_drain();
        program_reg(REG_WIDTH_CODE, 32'(WIDTH_8));
        program_reg(REG_POLYNOMIAL, 32'h0000_0031);
        program_reg(REG_LAST_INDEX, 32'd5);
        flash_bytes.push_back(8'h9A);
        flash_bytes.push_back(8'hBC);
        flash_bytes.push_back(8'hDE);

        random_bytes_sent = 0;
        while (random_bytes_sent < RANDOM_BYTES) begin
            wc = ($urandom_range(0, 7) == 0) ? WIDTH_INVALID
                                             : width_code_t'($urandom_range(0, 2));
            r = $urandom_range(0, 7);
            poly = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom());
            emb = ($urandom_range(0, 3) != 0);
            last = ($urandom_range(0, 5) == 0) ? 32'($urandom_range(12, 40))
                                               : 32'($urandom_range(0, 11));
            set_config(wc, poly, emb, last);
            src_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 13;
            sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
            runs = $urandom_range(1, 4);
            repeat (runs) begin
                r = $urandom_range(0, 9);
                queue_run(last + 1, r < 8, r == 7);
            end
        end

        wait_for_drain();
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("flash_crc_verifier_core verification clean");
        end else begin
            $display("flash_crc_verifier_core verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/fcv_pkg.sv
src/fcv_byte_update.sv
src/flash_crc_verifier_core.sv
dv/tb_flash_crc_verifier_core.sv
